// ----- src/brsi_pkg.sv -----
// Shared constants and controller/datapath interface types for the byte range set index.
package brsi_pkg;

	localparam int MAX_RANGES_DEF = 64;
	localparam int OFFSET_BITS    = 48;
	localparam int POS_BITS       = OFFSET_BITS + 1;

	localparam logic [2:0] REQ_ADD      = 3'd0;
	localparam logic [2:0] REQ_CONTAINS = 3'd1;
	localparam logic [2:0] REQ_AVAIL    = 3'd2;
	localparam logic [2:0] REQ_HOLE     = 3'd3;
	localparam logic [2:0] REQ_CLEAR    = 3'd4;

	typedef struct packed {
		logic load;
		logic rd;
		logic ev;
		logic ev2;
		logic fin;
		logic cmt;
		logic push;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic scan_end;
		logic need2;
		logic out_free;
	} sts_t;

endpackage

// ----- src/brsi_dp.sv -----
// Datapath: range list banks, scan evaluation, result and output registers.
module brsi_dp #(
	parameter int MAX_RANGES = brsi_pkg::MAX_RANGES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  brsi_pkg::cmd_t                   cmd,
	output brsi_pkg::sts_t                   sts,
	input  logic [2:0]                       req_type,
	input  logic [brsi_pkg::OFFSET_BITS-1:0] offset,
	input  logic [brsi_pkg::OFFSET_BITS-1:0] length,
	input  logic [brsi_pkg::POS_BITS-1:0]    window_end,
	input  logic                             out_stall,
	output logic                             out_valid,
	output logic                             ok,
	output logic [brsi_pkg::POS_BITS-1:0]    avail_bytes,
	output logic [brsi_pkg::POS_BITS-1:0]    gap_start,
	output logic [brsi_pkg::POS_BITS-1:0]    gap_end,
	output logic                             table_full
);

	localparam int OB  = brsi_pkg::OFFSET_BITS;
	localparam int PB  = brsi_pkg::POS_BITS;
	localparam int AW  = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int CW  = $clog2(MAX_RANGES + 1);
	localparam int NW  = $clog2(MAX_RANGES + 2);
	localparam int MEM_DEPTH = 2 * (2 ** AW);

	// two banks: scan reads the live bank, an add rebuilds into the other
	logic [OB-1:0] mem_s [0:MEM_DEPTH-1];
	logic [PB-1:0] mem_e [0:MEM_DEPTH-1];
	logic [OB-1:0] rd_s_q;
	logic [PB-1:0] rd_e_q;

	logic [2:0]    req_q;
	logic [OB-1:0] off_q;
	logic [PB-1:0] wend_q;
	logic [PB-1:0] aend_q;
	logic [OB-1:0] s_q;
	logic [PB-1:0] e_q;
	logic [PB-1:0] cur_q;
	logic          placed_q;
	logic          contained_q;
	logic          done_q;
	logic [NW-1:0] n_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] count_q;
	logic          bank_q;

	logic          res_ok_q;
	logic [PB-1:0] res_avail_q;
	logic [PB-1:0] res_hs_q;
	logic [PB-1:0] res_he_q;
	logic          res_full_q;

	logic          out_valid_q;
	logic          ok_q;
	logic [PB-1:0] avail_q;
	logic [PB-1:0] hs_q;
	logic [PB-1:0] he_q;
	logic          full_q;

	logic          is_add;
	logic          wr_req;
	logic          need2;
	logic [OB-1:0] wr_s;
	logic [PB-1:0] wr_e;
	logic          wr_room;
	logic [PB-1:0] cs_ext;
	logic [PB-1:0] off_ext;
	logic [PB-1:0] hole_b;
	logic          commit;

	assign is_add  = (req_q == brsi_pkg::REQ_ADD);
	assign cs_ext  = {1'b0, rd_s_q};
	assign off_ext = {1'b0, off_q};
	assign hole_b  = (cs_ext < wend_q) ? cs_ext : wend_q;
	assign wr_room = (n_q < NW'(MAX_RANGES));
	assign commit  = cmd.cmt && is_add && !done_q && (n_q <= NW'(MAX_RANGES));

	always_comb begin
		wr_req = 1'b0;
		need2  = 1'b0;
		wr_s   = rd_s_q;
		wr_e   = rd_e_q;
		if (cmd.ev && is_add) begin
			if (rd_e_q < {1'b0, s_q}) begin
				wr_req = 1'b1;
			end else if (e_q < cs_ext) begin
				wr_req = 1'b1;
				if (!placed_q) begin
					// new range goes first, the stored one follows next cycle
					wr_s  = s_q;
					wr_e  = e_q;
					need2 = 1'b1;
				end
			end
		end else if (cmd.ev2) begin
			wr_req = 1'b1;
		end else if (cmd.fin && is_add && !done_q && !placed_q) begin
			wr_req = 1'b1;
			wr_s   = s_q;
			wr_e   = e_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_req && wr_room) begin
			mem_s[{~bank_q, n_q[AW-1:0]}] <= wr_s;
			mem_e[{~bank_q, n_q[AW-1:0]}] <= wr_e;
		end
		if (cmd.rd) begin
			rd_s_q <= mem_s[{bank_q, idx_q[AW-1:0]}];
			rd_e_q <= mem_e[{bank_q, idx_q[AW-1:0]}];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			bank_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load && req_type == brsi_pkg::REQ_CLEAR) begin
				count_q <= '0;
			end
			if (commit) begin
				count_q <= n_q[CW-1:0];
				bank_q  <= ~bank_q;
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q       <= req_type;
			off_q       <= offset;
			wend_q      <= window_end;
			aend_q      <= {1'b0, offset} + {1'b0, length};
			s_q         <= offset;
			e_q         <= {1'b0, offset} + {1'b0, length};
			cur_q       <= {1'b0, offset};
			placed_q    <= 1'b0;
			contained_q <= 1'b0;
			n_q         <= '0;
			idx_q       <= '0;
			res_ok_q    <= (req_type == brsi_pkg::REQ_CONTAINS) && (length == '0);
			res_avail_q <= '0;
			res_hs_q    <= '0;
			res_he_q    <= '0;
			res_full_q  <= 1'b0;
			case (req_type)
				brsi_pkg::REQ_ADD:      done_q <= (length == '0);
				brsi_pkg::REQ_CONTAINS: done_q <= (length == '0);
				brsi_pkg::REQ_AVAIL:    done_q <= 1'b0;
				brsi_pkg::REQ_HOLE:     done_q <= (window_end <= {1'b0, offset});
				default:                done_q <= 1'b1;
			endcase
		end
		if (wr_req) begin
			n_q <= n_q + NW'(1);
		end
		if (cmd.ev) begin
			idx_q <= idx_q + CW'(1);
			case (req_q)
				brsi_pkg::REQ_ADD: begin
					if (rd_e_q < {1'b0, s_q}) begin
					end else if (e_q < cs_ext) begin
						placed_q <= 1'b1;
					end else begin
						if (rd_s_q < s_q) s_q <= rd_s_q;
						if (rd_e_q > e_q) e_q <= rd_e_q;
						if (rd_s_q <= off_q && rd_e_q >= aend_q) contained_q <= 1'b1;
					end
				end
				brsi_pkg::REQ_CONTAINS: begin
					if (rd_s_q <= off_q && rd_e_q >= aend_q) begin
						res_ok_q <= 1'b1;
						done_q   <= 1'b1;
					end else if (rd_s_q > off_q) begin
						done_q <= 1'b1;
					end
				end
				brsi_pkg::REQ_AVAIL: begin
					if (rd_s_q <= off_q && rd_e_q > off_ext) begin
						res_avail_q <= rd_e_q - off_ext;
						done_q      <= 1'b1;
					end else if (rd_s_q > off_q) begin
						done_q <= 1'b1;
					end
				end
				brsi_pkg::REQ_HOLE: begin
					if (rd_e_q <= cur_q) begin
					end else if (cs_ext > cur_q) begin
						if (hole_b > cur_q) begin
							res_ok_q <= 1'b1;
							res_hs_q <= cur_q;
							res_he_q <= hole_b;
						end
						done_q <= 1'b1;
					end else begin
						cur_q <= rd_e_q;
						if (rd_e_q >= wend_q) done_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
		if (cmd.fin && req_q == brsi_pkg::REQ_HOLE && !done_q && wend_q > cur_q) begin
			res_ok_q <= 1'b1;
			res_hs_q <= cur_q;
			res_he_q <= wend_q;
		end
		if (cmd.cmt && is_add && !done_q) begin
			if (n_q > NW'(MAX_RANGES)) begin
				res_full_q <= 1'b1;
			end else begin
				res_ok_q <= ~contained_q;
			end
		end
		if (cmd.push) begin
			ok_q    <= res_ok_q;
			avail_q <= res_avail_q;
			hs_q    <= res_hs_q;
			he_q    <= res_he_q;
			full_q  <= res_full_q;
		end
	end

	assign sts.done     = done_q;
	assign sts.scan_end = (idx_q == count_q);
	assign sts.need2    = need2;
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign ok          = ok_q;
	assign avail_bytes = avail_q;
	assign gap_start   = hs_q;
	assign gap_end     = he_q;
	assign table_full  = full_q;

endmodule

// ----- src/brsi_ctrl.sv -----
// Controller: sequences the list scan, the add rebuild, commit and result hand-off.
module brsi_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  brsi_pkg::sts_t sts,
	output brsi_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_EV,
		S_EV2,
		S_FIN,
		S_CMT,
		S_OUT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_RD;
				S_RD: begin
					if (sts.done || sts.scan_end) state_q <= S_FIN;
					else state_q <= S_EV;
				end
				S_EV: begin
					if (sts.need2) state_q <= S_EV2;
					else state_q <= S_RD;
				end
				S_EV2: state_q <= S_RD;
				S_FIN: state_q <= S_CMT;
				S_CMT: state_q <= S_OUT;
				S_OUT: if (sts.out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd      = '0;
		cmd.load = (state_q == S_IDLE) && in_valid;
		cmd.rd   = (state_q == S_RD) && !(sts.done || sts.scan_end);
		cmd.ev   = (state_q == S_EV);
		cmd.ev2  = (state_q == S_EV2);
		cmd.fin  = (state_q == S_FIN);
		cmd.cmt  = (state_q == S_CMT);
		cmd.push = (state_q == S_OUT) && sts.out_free;
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

// ----- src/byte_range_set_index_top.sv -----
// Top level of the byte range set index: sorted disjoint range list with merge and lookups.
// One item is worked at a time. Each request walks the stored ranges one entry at a time,
// a registered memory read (S_RD) and then an evaluation (S_EV); an add spends an extra
// state (S_EV2) where the new range is slotted in. A query stops early once resolved, and
// clear and unused codes skip the walk. An add rebuilds the list into a second bank and
// swaps banks on success, so a refused add leaves the list untouched. A finished result
// sits in an output register while the next item is taken.
module byte_range_set_index_top #(
	parameter int MAX_RANGES = brsi_pkg::MAX_RANGES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [2:0]                       req_type,
	input  logic [brsi_pkg::OFFSET_BITS-1:0] offset,
	input  logic [brsi_pkg::OFFSET_BITS-1:0] length,
	input  logic [brsi_pkg::POS_BITS-1:0]    window_end,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             ok,
	output logic [brsi_pkg::POS_BITS-1:0]    avail_bytes,
	output logic [brsi_pkg::POS_BITS-1:0]    gap_start,
	output logic [brsi_pkg::POS_BITS-1:0]    gap_end,
	output logic                             table_full
);

	brsi_pkg::cmd_t cmd;
	brsi_pkg::sts_t sts;

	brsi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	brsi_dp #(
		.MAX_RANGES (MAX_RANGES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req_type    (req_type),
		.offset      (offset),
		.length      (length),
		.window_end  (window_end),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.ok          (ok),
		.avail_bytes (avail_bytes),
		.gap_start   (gap_start),
		.gap_end     (gap_end),
		.table_full  (table_full)
	);

	a_full_not_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(table_full && ok))
		else $error("refused add reported as ok");

	a_hole_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && gap_end != '0) |-> (gap_end > gap_start))
		else $error("hole end not above hole start");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("item accepted without leaving idle");

endmodule

// ----- dv/tb.sv -----
// Testbench for the byte range set index: queued stimulus, clocked driver and monitor, predictor.
`timescale 1ns / 1ps
module tb;

	localparam int NRANGES = brsi_pkg::MAX_RANGES_DEF;
	localparam int OB      = brsi_pkg::OFFSET_BITS;
	localparam int PB      = brsi_pkg::POS_BITS;

	typedef struct {
		logic [2:0]    req;
		logic [OB-1:0] off;
		logic [OB-1:0] len;
		logic [PB-1:0] wend;
	} req_item_t;

	typedef struct {
		logic          ok;
		logic [PB-1:0] avail;
		logic [PB-1:0] hs;
		logic [PB-1:0] he;
		logic          full;
	} answer_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [2:0] req_type = '0;
	logic [OB-1:0] offset = '0;
	logic [OB-1:0] length = '0;
	logic [PB-1:0] window_end = '0;
	logic out_valid;
	logic out_stall = 0;
	logic ok, table_full;
	logic [PB-1:0] avail_bytes, gap_start, gap_end;

	byte_range_set_index_top i_dut (.*);

	always #1 clk = ~clk;

	// predictor's copy of the list
	logic [PB-1:0] span_lo[NRANGES];
	logic [PB-1:0] span_hi[NRANGES];
	int span_cnt = 0;

	req_item_t pending[$];
	answer_t   awaited[$];
	int errors = 0;
	bit quiet = 0;
	int hold_off = 0;
	int gap = 0;

	function automatic answer_t serve_request(req_item_t it);
		answer_t r;
		logic [PB-1:0] s, e, cs, ce, cur, b;
		logic [PB-1:0] ns[NRANGES+1];
		logic [PB-1:0] ne[NRANGES+1];
		int n;
		bit placed, hit;
		r = '{0, 0, 0, 0, 0};
		case (it.req)
		brsi_pkg::REQ_ADD: begin
			if (it.len != 0) begin
				s = {1'b0, it.off}; e = {1'b0, it.off} + {1'b0, it.len}; n = 0; placed = 0;
				for (int i = 0; i < span_cnt; i++) begin
					cs = span_lo[i]; ce = span_hi[i];
					if (ce < s) begin
						ns[n] = cs; ne[n] = ce; n++;
					end else if (e < cs) begin
						if (!placed) begin
							ns[n] = s; ne[n] = e; n++; placed = 1;
						end
						ns[n] = cs; ne[n] = ce; n++;
					end else begin
						if (cs < s) s = cs;
						if (ce > e) e = ce;
					end
				end
				if (!placed) begin
					ns[n] = s; ne[n] = e; n++;
				end
				if (n > NRANGES) r.full = 1;
				else begin
					if (n != span_cnt) r.ok = 1;
					else for (int i = 0; i < n; i++)
						if (ns[i] != span_lo[i] || ne[i] != span_hi[i]) r.ok = 1;
					for (int i = 0; i < n; i++) begin
						span_lo[i] = ns[i]; span_hi[i] = ne[i];
					end
					span_cnt = n;
				end
			end
		end
		brsi_pkg::REQ_CONTAINS: begin
			e = {1'b0, it.off} + {1'b0, it.len};
			if (it.len == 0) r.ok = 1;
			else for (int i = 0; i < span_cnt; i++) begin
				if (span_lo[i] <= {1'b0, it.off} && span_hi[i] >= e) begin
					r.ok = 1; break;
				end
				if (span_lo[i] > {1'b0, it.off}) break;
			end
		end
		brsi_pkg::REQ_AVAIL: begin
			for (int i = 0; i < span_cnt; i++) begin
				if (span_lo[i] <= {1'b0, it.off} && span_hi[i] > {1'b0, it.off}) begin
					r.avail = span_hi[i] - {1'b0, it.off}; break;
				end
				if (span_lo[i] > {1'b0, it.off}) break;
			end
		end
		brsi_pkg::REQ_HOLE: begin
			if (it.wend > {1'b0, it.off}) begin
				cur = {1'b0, it.off}; hit = 0;
				for (int i = 0; i < span_cnt; i++) begin
					if (span_hi[i] <= cur) continue;
					if (span_lo[i] > cur) begin
						b = span_lo[i] < it.wend ? span_lo[i] : it.wend;
						if (b > cur) begin
							r.ok = 1; r.hs = cur; r.he = b;
						end
						hit = 1; break;
					end
					cur = span_hi[i];
					if (cur >= it.wend) begin
						hit = 1; break;
					end
				end
				if (!hit && it.wend > cur) begin
					r.ok = 1; r.hs = cur; r.he = it.wend;
				end
			end
		end
		brsi_pkg::REQ_CLEAR: span_cnt = 0;
		default: ;
		endcase
		return r;
	endfunction

	// driver: random idle gaps, none once quiet
	always @(posedge clk) begin
		req_item_t it;
		if (in_valid && !in_stall) begin
			awaited.insert(awaited.size(), serve_request(pending.pop_front()));
		end
		if (in_valid && in_stall) begin
			// stalled item stays on the bus
		end else if (gap > 0) begin
			gap <= gap - 1;
			in_valid <= 0;
		end else if (pending.size() == 0) begin
			in_valid <= 0;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			gap <= $urandom_range(0, 14);
			in_valid <= 0;
		end else begin
			it = pending[0];
			in_valid <= 1;
			req_type <= it.req; offset <= it.off; length <= it.len; window_end <= it.wend;
		end
	end

	// receiver stall bursts, plus one long hold-off
	int burst = 0;
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_stall <= 1;
		end else if (quiet) out_stall <= 0;
		else if (burst > 0) begin
			burst <= burst - 1; out_stall <= 1;
		end else if ($urandom_range(0, 19) == 0) begin
			burst <= $urandom_range(0, 14); out_stall <= 1;
		end else out_stall <= 0;
	end

	// monitor
	always @(posedge clk) begin
		answer_t x;
		if (out_valid && !out_stall) begin
			if (awaited.size() == 0) begin
				$display("%0t: unexpected result", $time);
				errors++;
			end else begin
				x = awaited.pop_front();
				if (ok !== x.ok) begin
					$display("%0t: ok exp %0d got %0d", $time, x.ok, ok); errors++;
				end
				if (avail_bytes !== x.avail) begin
					$display("%0t: avail exp %0h got %0h", $time, x.avail, avail_bytes);
					errors++;
				end
				if (gap_start !== x.hs) begin
					$display("%0t: gap_start exp %0h got %0h", $time, x.hs, gap_start);
					errors++;
				end
				if (gap_end !== x.he) begin
					$display("%0t: gap_end exp %0h got %0h", $time, x.he, gap_end);
					errors++;
				end
				if (table_full !== x.full) begin
					$display("%0t: table_full exp %0d got %0d", $time, x.full, table_full);
					errors++;
				end
			end
		end
	end

	function automatic logic [OB-1:0] rnd48();
		return OB'({$urandom, $urandom});
	endfunction

	task automatic queue_req(logic [2:0] rq, logic [OB-1:0] o,
		logic [OB-1:0] l, logic [PB-1:0] w);
		pending.insert(pending.size(), '{rq, o, l, w});
	endtask

	initial begin
		logic [OB-1:0] base, o;
		int mode;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		// directed
		queue_req(brsi_pkg::REQ_ADD, 100, 0, 0);
		queue_req(brsi_pkg::REQ_CONTAINS, 5, 0, 0);
		queue_req(brsi_pkg::REQ_HOLE, 10, 0, 5);
		queue_req(brsi_pkg::REQ_HOLE, 10, 0, 10);
		queue_req(brsi_pkg::REQ_HOLE, 0, 0, {PB{1'b1}});
		queue_req(brsi_pkg::REQ_ADD, 100, 50, 0);
		queue_req(brsi_pkg::REQ_ADD, 100, 50, 0);
		queue_req(brsi_pkg::REQ_ADD, 150, 10, 0);
		queue_req(brsi_pkg::REQ_ADD, 40, 60, 0);
		queue_req(brsi_pkg::REQ_CONTAINS, 40, 120, 0);
		queue_req(brsi_pkg::REQ_CONTAINS, 39, 5, 0);
		queue_req(brsi_pkg::REQ_AVAIL, 70, 0, 0);
		queue_req(brsi_pkg::REQ_AVAIL, 160, 0, 0);
		queue_req(brsi_pkg::REQ_HOLE, 50, 0, 150);
		queue_req(brsi_pkg::REQ_HOLE, 0, 0, 300);
		queue_req(brsi_pkg::REQ_ADD, {OB{1'b1}}, {OB{1'b1}}, 0);
		queue_req(brsi_pkg::REQ_AVAIL, {OB{1'b1}}, 0, 0);
		queue_req(brsi_pkg::REQ_HOLE, 200, 0, {PB{1'b1}});
		queue_req(3'd5, 1, 2, 3);
		queue_req(3'd6, 0, 0, 0);
		queue_req(3'd7, {OB{1'b1}}, {OB{1'b1}}, {PB{1'b1}});
		queue_req(brsi_pkg::REQ_CLEAR, 0, 0, 0);
		// fill past capacity to hit the full table
		for (int i = 0; i <= NRANGES + 1; i++) queue_req(brsi_pkg::REQ_ADD, OB'(i * 10), 3, 0);
		queue_req(brsi_pkg::REQ_ADD, 2, 3, 0);
		queue_req(brsi_pkg::REQ_CLEAR, 0, 0, 0);
		// random: mostly dense small ranges, some wide noise
		for (int k = 0; k < 1880; k++) begin
			if (k == 300) begin
				wait (pending.size() == 0);
				hold_off = 400;
			end
			if (k == 1700) begin
				wait (pending.size() == 0);
				quiet = 1;
			end
			mode = $urandom_range(0, 9);
			base = (mode == 0) ? rnd48() : OB'($urandom_range(0, 2000));
			o = (mode == 0) ? rnd48() : OB'($urandom_range(0, 1500));
			case ($urandom_range(0, 19))
			0: queue_req(brsi_pkg::REQ_CLEAR, rnd48(), rnd48(), {rnd48(), 1'b0});
			1: queue_req(3'($urandom_range(5, 7)), rnd48(), rnd48(),
				{1'($urandom_range(0, 1)), rnd48()});
			2, 3, 4, 5, 6, 7, 8:
				queue_req(brsi_pkg::REQ_ADD, base,
					mode == 0 ? rnd48() : OB'($urandom_range(0, 40)), 0);
			9, 10, 11: queue_req(brsi_pkg::REQ_CONTAINS, o,
				mode == 0 ? rnd48() : OB'($urandom_range(0, 60)), 0);
			12, 13, 14: queue_req(brsi_pkg::REQ_AVAIL, o, rnd48(), 0);
			default: queue_req(brsi_pkg::REQ_HOLE, o, rnd48(),
				mode == 0 ? {1'($urandom_range(0, 1)), rnd48()}
					: PB'({1'b0, o} + PB'($urandom_range(0, 300)) - PB'(20)));
			endcase
		end
		wait (pending.size() == 0 && awaited.size() == 0);
		repeat (300) @(posedge clk);
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

	initial begin
		#3000000;
		$display("DONE: errors detected");
		$finish;
	end
endmodule
